>>> rtl/core/bsrs_pkg.sv
package bsrs_pkg;

	localparam int unsigned MaxBlockedDefault = 256;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_PICK   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic        go;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] remainder;
	} div_rsp_t;

endpackage

>>> rtl/core/bsrs_divider.sv
module bsrs_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  bsrs_pkg::div_req_t  req,
	output bsrs_pkg::div_rsp_t  rsp
);
	import bsrs_pkg::*;

	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	// One quotient bit per cycle, restoring form. The partial remainder stays
	// below the divisor, so it always fits in 32 bits.
	assign shifted = {rem_q, dvd_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= diff[32] ? shifted[31:0] : diff[31:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

>>> rtl/core/blacklist_skipping_rank_select.sv
// Blacklist-skipping uniform picker.
// A command beat is accepted when start is high and busy is low; op selects
// clear (0), insert of blocked_value (1) or pick with random_word (2). Each
// command yields exactly one result beat: done pulses for one cycle with
// picked and status valid. The receiver cannot stall, so results are never
// held back. range_size is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Blocked values are kept sorted in a single-port synchronous memory, and
// the run table (starts and prefix sums) lives in two more memories.
// Clear, an unused op, an out-of-range insert and a pick with nothing
// allowed on a fresh table answer in the next cycle.
// Insert scans the store for its slot and then shifts the tail. Pick divides
// the random word by the allowed total for a remainder, binary-searches
// the prefix sums (up to 9 steps with the default MAX_BLOCKED) and fetches
// the run; a table rebuild comes first when the store or range_size changed
// since the last pick. busy drops with the result beat, so the next command
// can be accepted at the edge ending it.
// Reset empties the store, sets range_size to 1 and marks the table stale;
// memory contents are not cleared and need no clearing pass.
module blacklist_skipping_rank_select #(
	parameter int unsigned MAX_BLOCKED = bsrs_pkg::MaxBlockedDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] blocked_value,
	input  logic [30:0] random_word,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        done,
	output logic [31:0] picked,
	output logic [1:0]  status
);
	import bsrs_pkg::*;

	localparam int CW = $clog2(MAX_BLOCKED + 2);
	localparam int AW = (MAX_BLOCKED > 1) ? $clog2(MAX_BLOCKED) : 1;
	localparam int RW = $clog2(MAX_BLOCKED + 1);
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_BLOCKED);
	localparam logic [CW-1:0] RunMax = CW'(MAX_BLOCKED + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCANRD = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_SHRD   = 4'd3;
	localparam logic [3:0] S_SHWR   = 4'd4;
	localparam logic [3:0] S_BRD    = 4'd5;
	localparam logic [3:0] S_BUILD  = 4'd6;
	localparam logic [3:0] S_BTAIL  = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_SRD    = 4'd9;
	localparam logic [3:0] S_SCMP   = 4'd10;
	localparam logic [3:0] S_FRD    = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	// Memories.
	logic [31:0] store_mem [MAX_BLOCKED];
	logic [31:0] start_mem [MAX_BLOCKED+1];
	logic [31:0] pref_mem  [MAX_BLOCKED+1];
	logic [31:0] store_rd, start_rd, pref_rd;
	logic [AW-1:0] st_addr;
	logic          st_we;
	logic [31:0]   st_wd;
	logic [RW-1:0] rt_addr;
	logic          rt_we;
	logic [31:0]   rt_start_wd, rt_pref_wd;

	always_ff @(posedge clk) begin
		if (st_we) store_mem[st_addr] <= st_wd;
		store_rd <= store_mem[st_addr];
	end
	always_ff @(posedge clk) begin
		if (rt_we) begin
			start_mem[rt_addr] <= rt_start_wd;
			pref_mem[rt_addr]  <= rt_pref_wd;
		end
		start_rd <= start_mem[rt_addr];
		pref_rd  <= pref_mem[rt_addr];
	end

	logic [3:0]    state_q;
	logic [31:0]   range_q;
	logic [CW-1:0] bcnt_q;
	logic [CW-1:0] rcnt_q;
	logic [31:0]   total_q;
	logic          stale_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   val_q;
	logic [31:0]   carry_q;
	logic [32:0]   next_q;
	logic [30:0]   rnd_q;
	logic [31:0]   rem_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [31:0]   base_q;
	logic          done_q;
	logic [31:0]   picked_q;
	logic [1:0]    status_q;

	div_req_t dreq;
	div_rsp_t drsp;

	bsrs_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [CW-1:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Index of the run before the selected one; only read when lo_q is nonzero.
	logic [CW-1:0] lo_prev;
	assign lo_prev = (lo_q == '0) ? '0 : lo_q - CW'(1);

	// Run add during rebuild.
	logic          add_en;
	logic [31:0]   add_start, add_len;

	always_comb begin
		st_addr     = idx_q[AW-1:0];
		st_we       = 1'b0;
		st_wd       = carry_q;
		rt_addr     = rcnt_q[RW-1:0];
		rt_we       = 1'b0;
		dreq.go       = 1'b0;
		dreq.dividend = {1'b0, rnd_q};
		dreq.divisor  = total_q;
		add_en    = 1'b0;
		add_start = next_q[31:0];
		add_len   = 32'd0;
		case (state_q)
			S_SHWR: st_we = 1'b1;
			S_BUILD: begin
				if ({1'b0, store_rd} < {1'b0, range_q} && {1'b0, store_rd} > next_q) begin
					add_en  = 1'b1;
					add_len = store_rd - next_q[31:0];
				end
			end
			S_BTAIL: begin
				if ({1'b0, range_q} > next_q) begin
					add_en  = 1'b1;
					add_len = range_q - next_q[31:0];
				end
			end
			S_SRD: rt_addr = mid[RW-1:0];
			S_FRD: rt_addr = lo_prev[RW-1:0];
			default: ;
		endcase
		rt_start_wd = add_start;
		rt_pref_wd  = total_q + add_len;
		if (add_en && rcnt_q < RunMax) rt_we = 1'b1;
		if (state_q == S_IDLE && start && op == OP_PICK && !stale_q
				&& total_q != 32'd0 && rcnt_q != '0) begin
			dreq.go       = 1'b1;
			dreq.dividend = {1'b0, random_word};
		end
		if (state_q == S_BTAIL && total_q + add_len != 32'd0 && (rcnt_q != '0 || rt_we)
				&& !(!add_en && total_q == 32'd0)) begin
			dreq.go       = 1'b1;
			dreq.dividend = {1'b0, rnd_q};
			dreq.divisor  = rt_we ? total_q + add_len : total_q;
		end
	end

	task automatic finish(input logic [1:0] st, input logic [31:0] pk);
		done_q   <= 1'b1;
		status_q <= st;
		picked_q <= pk;
		state_q  <= S_IDLE;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			range_q  <= 32'd1;
			bcnt_q   <= '0;
			rcnt_q   <= '0;
			total_q  <= '0;
			stale_q  <= 1'b1;
			done_q   <= 1'b0;
			picked_q <= '0;
			status_q <= ST_OK;
			idx_q    <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				range_q <= cfg_wdata;
				stale_q <= 1'b1;
			end
			if (rt_we) begin
				rcnt_q  <= rcnt_q + CW'(1);
				total_q <= total_q + add_len;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q <= blocked_value;
						rnd_q <= random_word;
						idx_q <= '0;
						case (op)
							OP_CLEAR: begin
								bcnt_q  <= '0;
								stale_q <= 1'b1;
								finish(ST_OK, 32'd0);
							end
							OP_INSERT: begin
								if (blocked_value >= range_q) finish(ST_RANGE, 32'd0);
								else state_q <= S_SCANRD;
							end
							OP_PICK: begin
								if (stale_q) begin
									rcnt_q  <= '0;
									total_q <= '0;
									next_q  <= '0;
									stale_q <= 1'b0;
									state_q <= (bcnt_q == '0) ? S_BTAIL : S_BRD;
								end else if (dreq.go) begin
									state_q <= S_DIV;
								end else begin
									finish(ST_NONE, 32'd0);
								end
							end
							default: finish(ST_OK, 32'd0);
						endcase
					end
				end
				// Insert: find first entry not below the value.
				S_SCANRD: begin
					if (idx_q >= bcnt_q) begin
						if (bcnt_q >= MaxCnt) finish(ST_FULL, 32'd0);
						else begin
							carry_q <= val_q;
							state_q <= S_SHRD;
						end
					end else state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (store_rd < val_q) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCANRD;
					end else if (store_rd == val_q) finish(ST_OK, 32'd0);
					else if (bcnt_q >= MaxCnt) finish(ST_FULL, 32'd0);
					else begin
						carry_q <= val_q;
						state_q <= S_SHRD;
					end
				end
				// Shift the tail up one slot, carrying the displaced entry.
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					carry_q <= store_rd;
					if (idx_q >= bcnt_q) begin
						bcnt_q  <= bcnt_q + CW'(1);
						stale_q <= 1'b1;
						finish(ST_OK, 32'd0);
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SHRD;
					end
				end
				// Rebuild the run table from the sorted store.
				S_BRD: state_q <= S_BUILD;
				S_BUILD: begin
					if ({1'b0, store_rd} >= {1'b0, range_q}) state_q <= S_BTAIL;
					else begin
						next_q <= {1'b0, store_rd} + 33'd1;
						if (idx_q + CW'(1) >= bcnt_q) state_q <= S_BTAIL;
						else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_BRD;
						end
					end
				end
				S_BTAIL: begin
					if (dreq.go) state_q <= S_DIV;
					else finish(ST_NONE, 32'd0);
				end
				S_DIV: begin
					if (drsp.done) begin
						rem_q   <= drsp.remainder;
						lo_q    <= '0;
						hi_q    <= rcnt_q - CW'(1);
						state_q <= S_SRD;
					end
				end
				// When the search has converged, the read issued here fetches
				// the start of the selected run.
				S_SRD: begin
					if (lo_q < hi_q) state_q <= S_SCMP;
					else state_q <= S_FRD;
				end
				S_SCMP: begin
					if (pref_rd > rem_q) hi_q <= mid;
					else lo_q <= mid + CW'(1);
					state_q <= S_SRD;
				end
				// Keep the run start and fetch the prefix of the run before it.
				S_FRD: begin
					base_q  <= start_rd;
					state_q <= S_FIN;
				end
				S_FIN: begin
					finish(ST_OK, base_q + (rem_q - ((lo_q == '0) ? 32'd0 : pref_rd)));
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign picked = picked_q;
	assign status = status_q;
	assign busy   = (state_q != S_IDLE);

endmodule
